// ----- rtl/dses_pkg.sv -----
// shared types, constants and helpers for the damped spring euler step unit
// no dependencies; used by the interfaces, the divider and the top level
package dses_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int MASS_W     = 31;
	localparam int DT_W       = 17;
	localparam int AXES       = 3;
	localparam int AX_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int MUL_A_W    = DATA_W + 1;
	localparam int PROD_W     = MUL_A_W + DATA_W;
	localparam int SHIFT_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W      = SHIFT_W + 1;
	localparam int FORCE_W    = SHIFT_W + 3;
	localparam int QSH        = DATA_W - FRAC_BITS;
	localparam int CNT_W      = $clog2(DATA_W);

	localparam logic signed [DATA_W-1:0] GRAVITY_Y = -32'sd981;
	localparam logic signed [DATA_W-1:0] S32_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN   = 32'sh8000_0000;

	localparam logic [MASS_W-1:0] MASS_RST  = 31'd1310720;
	localparam logic [MASS_W-1:0] STIFF_RST = 31'd983040000;
	localparam logic [MASS_W-1:0] DAMP_RST  = 31'd26214400;
	localparam logic [DT_W-1:0]   DT_RST    = 17'd1092;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	localparam logic [AX_W-1:0] AX_Y    = 2'd1;
	localparam logic [AX_W-1:0] AX_LAST = 2'(AXES - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE = 3'd0,
		CFG_MASS   = 3'd1,
		CFG_STIFF  = 3'd2,
		CFG_DAMP   = 3'd3,
		CFG_DT     = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_KMUL,
		ST_GMUL,
		ST_CMUL,
		ST_FSUM,
		ST_DSTART,
		ST_DWAIT,
		ST_AMUL,
		ST_VADD,
		ST_VMUL,
		ST_PADD,
		ST_FIN
	} seq_st_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN,
		DV_DONE
	} div_st_t;

	typedef struct packed {
		logic                     done;
		logic                     sat;
		logic signed [DATA_W-1:0] quot;
	} div_res_t;

	typedef struct packed {
		logic                     flag;
		logic signed [DATA_W-1:0] val;
	} sat_t;

	// clip a wide signed sum to 32 signed bits
	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t r;
		r.flag = 1'b0;
		r.val  = v[DATA_W-1:0];
		if (v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
			r.flag = 1'b1;
			r.val  = v[SUM_W-1] ? S32_MIN : S32_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/dses_cmd_if.sv -----
// command channel: action code and three anchor coordinates
// depends on dses_pkg for widths
interface dses_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic signed [dses_pkg::DATA_W-1:0] anchor_x;
	logic signed [dses_pkg::DATA_W-1:0] anchor_y;
	logic signed [dses_pkg::DATA_W-1:0] anchor_z;

	modport source (output valid, action, anchor_x, anchor_y, anchor_z, input ready);
	modport sink (input valid, action, anchor_x, anchor_y, anchor_z, output ready);
endinterface

// ----- rtl/dses_res_if.sv -----
// result channel: new position and clip flag
// depends on dses_pkg for widths
interface dses_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [dses_pkg::DATA_W-1:0] pos_x;
	logic signed [dses_pkg::DATA_W-1:0] pos_y;
	logic signed [dses_pkg::DATA_W-1:0] pos_z;
	logic                               saturated;

	modport source (output valid, pos_x, pos_y, pos_z, saturated, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

// ----- rtl/dses_div.sv -----
// serial restoring divider: force * 2^FRAC_BITS / mass, truncated toward zero, clipped
// one quotient bit per cycle; depends on dses_pkg
module dses_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [dses_pkg::FORCE_W-1:0] force_in,
	input  logic [dses_pkg::MASS_W-1:0]         divisor,
	output dses_pkg::div_res_t                  res
);

	dses_pkg::div_st_t st_q, st_d;

	logic [dses_pkg::FORCE_W-1:0] mag_q;
	logic                         neg_q;
	logic                         ovf_q;
	logic [dses_pkg::MASS_W-1:0]  dvs_q;
	logic [dses_pkg::MASS_W-1:0]  rem_q;
	logic [dses_pkg::DATA_W-1:0]  low_q;
	logic [dses_pkg::DATA_W-1:0]  quo_q;
	logic [dses_pkg::CNT_W-1:0]   cnt_q;

	logic                         ovf;
	logic [dses_pkg::MASS_W:0]    rem2;
	logic                         ge;
	logic [dses_pkg::MASS_W:0]    rem_sub;

	// quotient reaches 2^32 exactly when |force| >= mass << (32 - frac)
	assign ovf     = mag_q >= (dses_pkg::FORCE_W'(dvs_q) << dses_pkg::QSH);
	assign rem2    = {rem_q, low_q[dses_pkg::DATA_W-1]};
	assign ge      = rem2 >= {1'b0, dvs_q};
	assign rem_sub = rem2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dses_pkg::DV_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			dses_pkg::DV_IDLE:  if (start) st_d = dses_pkg::DV_CHECK;
			dses_pkg::DV_CHECK: st_d = ovf ? dses_pkg::DV_DONE : dses_pkg::DV_RUN;
			dses_pkg::DV_RUN: begin
				if (cnt_q == dses_pkg::CNT_W'(dses_pkg::DATA_W - 1)) st_d = dses_pkg::DV_DONE;
			end
			dses_pkg::DV_DONE:  st_d = dses_pkg::DV_IDLE;
			default:            st_d = dses_pkg::DV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			dses_pkg::DV_IDLE: begin
				if (start) begin
					neg_q <= force_in[dses_pkg::FORCE_W-1];
					mag_q <= force_in[dses_pkg::FORCE_W-1] ? unsigned'(-force_in)
					                                       : unsigned'(force_in);
					dvs_q <= divisor;
				end
			end
			dses_pkg::DV_CHECK: begin
				ovf_q <= ovf;
				rem_q <= mag_q[dses_pkg::QSH +: dses_pkg::MASS_W];
				low_q <= {mag_q[dses_pkg::QSH-1:0], {dses_pkg::FRAC_BITS{1'b0}}};
				quo_q <= '0;
				cnt_q <= '0;
			end
			dses_pkg::DV_RUN: begin
				rem_q <= ge ? rem_sub[dses_pkg::MASS_W-1:0] : rem2[dses_pkg::MASS_W-1:0];
				quo_q <= {quo_q[dses_pkg::DATA_W-2:0], ge};
				low_q <= {low_q[dses_pkg::DATA_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// sign and clip of the unsigned quotient
	always_comb begin
		res.done = (st_q == dses_pkg::DV_DONE);
		res.sat  = 1'b0;
		res.quot = signed'(quo_q);
		if (ovf_q) begin
			res.sat  = 1'b1;
			res.quot = neg_q ? dses_pkg::S32_MIN : dses_pkg::S32_MAX;
		end else if (neg_q) begin
			if (quo_q > unsigned'(dses_pkg::S32_MIN)) begin
				res.sat  = 1'b1;
				res.quot = dses_pkg::S32_MIN;
			end else begin
				res.quot = signed'(-quo_q);
			end
		end else if (quo_q[dses_pkg::DATA_W-1]) begin
			res.sat  = 1'b1;
			res.quot = dses_pkg::S32_MAX;
		end
	end

endmodule

// ----- rtl/damped_spring_euler_step_unit.sv -----
// damped spring euler step unit: three-axis mass-spring-damper, fixed point
// depends on dses_pkg, dses_cmd_if, dses_res_if and dses_div
//
//  port   dir  what travels
//  cfg    in   write enable, register index, 31-bit data
//  cmd    in   action, anchor_x, anchor_y, anchor_z
//  res    out  pos_x, pos_y, pos_z, saturated
//
// a tick with enable set runs, per axis, ten sequencer steps, the multiplies among them
// through the one shared 33x32 multiplier, plus a wait on the serial divider
// a load, or a tick with enable clear, goes from idle straight to the finish step
// arst_n clears position, velocity and configuration registers to their reset values
// cmd is taken again while a finished result still waits on res

module damped_spring_euler_step_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dses_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dses_pkg::CFG_DATA_W-1:0]    cfg_data,
	dses_cmd_if.sink                           cmd,
	dses_res_if.source                         res
);

	dses_pkg::seq_st_t state_q, state_d;

	logic                              enable_q;
	logic [dses_pkg::MASS_W-1:0]       mass_q;
	logic [dses_pkg::MASS_W-1:0]       stiff_q;
	logic [dses_pkg::MASS_W-1:0]       damp_q;
	logic [dses_pkg::DT_W-1:0]         dt_q;

	logic signed [dses_pkg::DATA_W-1:0] pos_q    [dses_pkg::AXES];
	logic signed [dses_pkg::DATA_W-1:0] vel_q    [dses_pkg::AXES];
	logic signed [dses_pkg::DATA_W-1:0] anchor_q [dses_pkg::AXES];
	logic [dses_pkg::AX_W-1:0]          ax_q;
	logic                               sat_q;
	logic                               out_valid_q;
	logic                               sat_q_out_q;

	logic signed [dses_pkg::MUL_A_W-1:0] diff_q;
	logic signed [dses_pkg::PROD_W-1:0]  prod_q;
	logic signed [dses_pkg::FORCE_W-1:0] force_q;
	logic signed [dses_pkg::DATA_W-1:0]  acc_q;
	logic signed [dses_pkg::DATA_W-1:0]  outx_q, outy_q, outz_q;

	logic                                accept;
	logic                                div_start;
	logic                                out_load;
	dses_pkg::div_res_t                  div_res;
	logic [dses_pkg::MASS_W-1:0]         m_eff;
	logic signed [dses_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dses_pkg::DATA_W-1:0]  mul_b;
	logic signed [dses_pkg::PROD_W-1:0]  mul_p;
	logic signed [dses_pkg::FORCE_W-1:0] prod_f;
	logic signed [dses_pkg::SUM_W-1:0]   prod_s;
	logic signed [dses_pkg::DATA_W-1:0]  vel_cur;
	logic signed [dses_pkg::DATA_W-1:0]  pos_cur;
	dses_pkg::sat_t                      vel_new;
	dses_pkg::sat_t                      pos_new;

	assign accept  = cmd.valid && cmd.ready;
	assign m_eff   = (mass_q == '0) ? dses_pkg::MASS_W'(1) : mass_q;
	assign vel_cur = vel_q[ax_q];
	assign pos_cur = pos_q[ax_q];

	// product shifted down by the fraction bits, floor rounding
	assign prod_f = {{(dses_pkg::FORCE_W-dses_pkg::SHIFT_W){prod_q[dses_pkg::PROD_W-1]}},
	                 prod_q[dses_pkg::PROD_W-1:dses_pkg::FRAC_BITS]};
	assign prod_s = {prod_q[dses_pkg::PROD_W-1], prod_q[dses_pkg::PROD_W-1:dses_pkg::FRAC_BITS]};

	assign vel_new = dses_pkg::sat32(dses_pkg::SUM_W'(vel_cur) + prod_s);
	assign pos_new = dses_pkg::sat32(dses_pkg::SUM_W'(pos_cur) + prod_s);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			dses_pkg::ST_KMUL: begin
				mul_a = diff_q;
				mul_b = signed'({1'b0, stiff_q});
			end
			dses_pkg::ST_GMUL: begin
				mul_a = signed'({2'b00, m_eff});
				mul_b = dses_pkg::GRAVITY_Y;
			end
			dses_pkg::ST_CMUL: begin
				mul_a = dses_pkg::MUL_A_W'(vel_cur);
				mul_b = signed'({1'b0, damp_q});
			end
			dses_pkg::ST_AMUL: begin
				mul_a = dses_pkg::MUL_A_W'(acc_q);
				mul_b = signed'({{(dses_pkg::DATA_W-dses_pkg::DT_W){1'b0}}, dt_q});
			end
			dses_pkg::ST_VMUL: begin
				mul_a = dses_pkg::MUL_A_W'(vel_cur);
				mul_b = signed'({{(dses_pkg::DATA_W-dses_pkg::DT_W){1'b0}}, dt_q});
			end
			default: ;
		endcase
	end

	assign mul_p = {{dses_pkg::DATA_W{mul_a[dses_pkg::MUL_A_W-1]}}, mul_a}
	             * {{dses_pkg::MUL_A_W{mul_b[dses_pkg::DATA_W-1]}}, mul_b};

	dses_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.force_in (force_q),
		.divisor  (m_eff),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dses_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			dses_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if (cmd.action == dses_pkg::ACT_LOAD || !enable_q) begin
						state_d = dses_pkg::ST_FIN;
					end else begin
						state_d = dses_pkg::ST_DIFF;
					end
				end
			end
			dses_pkg::ST_DIFF:   state_d = dses_pkg::ST_KMUL;
			dses_pkg::ST_KMUL:   state_d = dses_pkg::ST_GMUL;
			dses_pkg::ST_GMUL:   state_d = dses_pkg::ST_CMUL;
			dses_pkg::ST_CMUL:   state_d = dses_pkg::ST_FSUM;
			dses_pkg::ST_FSUM:   state_d = dses_pkg::ST_DSTART;
			dses_pkg::ST_DSTART: begin
				div_start = 1'b1;
				state_d   = dses_pkg::ST_DWAIT;
			end
			dses_pkg::ST_DWAIT:  if (div_res.done) state_d = dses_pkg::ST_AMUL;
			dses_pkg::ST_AMUL:   state_d = dses_pkg::ST_VADD;
			dses_pkg::ST_VADD:   state_d = dses_pkg::ST_VMUL;
			dses_pkg::ST_VMUL:   state_d = dses_pkg::ST_PADD;
			dses_pkg::ST_PADD: begin
				state_d = (ax_q == dses_pkg::AX_LAST) ? dses_pkg::ST_FIN : dses_pkg::ST_DIFF;
			end
			dses_pkg::ST_FIN: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = dses_pkg::ST_IDLE;
				end
			end
			default: state_d = dses_pkg::ST_IDLE;
		endcase
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			mass_q      <= dses_pkg::MASS_RST;
			stiff_q     <= dses_pkg::STIFF_RST;
			damp_q      <= dses_pkg::DAMP_RST;
			dt_q        <= dses_pkg::DT_RST;
			ax_q        <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < dses_pkg::AXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dses_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
					dses_pkg::CFG_MASS:   mass_q   <= cfg_data;
					dses_pkg::CFG_STIFF:  stiff_q  <= cfg_data;
					dses_pkg::CFG_DAMP:   damp_q   <= cfg_data;
					dses_pkg::CFG_DT:     dt_q     <= cfg_data[dses_pkg::DT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				ax_q  <= '0;
				sat_q <= 1'b0;
				if (cmd.action == dses_pkg::ACT_LOAD) begin
					pos_q[0] <= cmd.anchor_x;
					pos_q[1] <= cmd.anchor_y;
					pos_q[2] <= cmd.anchor_z;
					for (int i = 0; i < dses_pkg::AXES; i++) begin
						vel_q[i] <= '0;
					end
				end
			end
			if (state_q == dses_pkg::ST_DWAIT && div_res.done) begin
				sat_q <= sat_q | div_res.sat;
			end
			if (state_q == dses_pkg::ST_VADD) begin
				vel_q[ax_q] <= vel_new.val;
				sat_q       <= sat_q | vel_new.flag;
			end
			if (state_q == dses_pkg::ST_PADD) begin
				pos_q[ax_q] <= pos_new.val;
				sat_q       <= sat_q | pos_new.flag;
				ax_q        <= ax_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			anchor_q[0] <= cmd.anchor_x;
			anchor_q[1] <= cmd.anchor_y;
			anchor_q[2] <= cmd.anchor_z;
		end
		case (state_q)
			dses_pkg::ST_DIFF: begin
				diff_q <= dses_pkg::MUL_A_W'(pos_cur) - dses_pkg::MUL_A_W'(anchor_q[ax_q]);
			end
			dses_pkg::ST_KMUL: prod_q <= mul_p;
			dses_pkg::ST_GMUL: begin
				force_q <= -prod_f;
				prod_q  <= mul_p;
			end
			dses_pkg::ST_CMUL: begin
				// gravity acts on y only
				if (ax_q == dses_pkg::AX_Y) begin
					force_q <= force_q + prod_q[dses_pkg::FORCE_W-1:0];
				end
				prod_q <= mul_p;
			end
			dses_pkg::ST_FSUM:  force_q <= force_q - prod_f;
			dses_pkg::ST_DWAIT: if (div_res.done) acc_q <= div_res.quot;
			dses_pkg::ST_AMUL:  prod_q <= mul_p;
			dses_pkg::ST_VMUL:  prod_q <= mul_p;
			default: ;
		endcase
		if (out_load) begin
			outx_q <= pos_q[0];
			outy_q <= pos_q[1];
			outz_q <= pos_q[2];
		end
	end

	assign res.valid     = out_valid_q;
	assign res.pos_x     = outx_q;
	assign res.pos_y     = outy_q;
	assign res.pos_z     = outz_q;
	assign res.saturated = out_valid_q & sat_q_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q_out_q <= 1'b0;
		end else if (out_load) begin
			sat_q_out_q <= sat_q;
		end
	end

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == dses_pkg::ST_DWAIT)
		else $error("divider finished outside of the wait step");

	// after a tick the finish step sees the axis count already past the last axis
	a_axis_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dses_pkg::ST_IDLE && state_q != dses_pkg::ST_FIN) |->
		ax_q <= dses_pkg::AX_LAST)
		else $error("axis index out of range");

	a_load_short: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.action == dses_pkg::ACT_LOAD) |=> state_q == dses_pkg::ST_FIN)
		else $error("load item did not go straight to finish");

	a_load_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.action == dses_pkg::ACT_LOAD) |=>
		(vel_q[0] == '0 && vel_q[1] == '0 && vel_q[2] == '0))
		else $error("velocity not cleared by load");
`endif

endmodule
